// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define DLV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define DLV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dlv_pkg.sv =====
`timescale 1ns / 1ps

package dlv_pkg;

  localparam int MAX_ARGS    = 512;
  localparam int CNT_W       = $clog2(MAX_ARGS + 1);
  localparam int VALUE_W     = 32;
  localparam int ARG_COUNT_W = 10;
  localparam int KIND_W      = 2;
  localparam int CH_W        = 8;
  localparam int PROD_W      = VALUE_W + 4;

  localparam logic [KIND_W-1:0] KIND_CHAR     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARG_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST_END = 2'd2;

  localparam logic [1:0] POS_EMPTY  = 2'd0;
  localparam logic [1:0] POS_SIGN   = 2'd1;
  localparam logic [1:0] POS_DIGITS = 2'd2;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;

  localparam logic [PROD_W-1:0] POS_LIMIT = 36'h0_7FFF_FFFF;
  localparam logic [PROD_W-1:0] NEG_LIMIT = 36'h0_8000_0000;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic               empty;
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic               rexc;
    logic               ferr;
  } arg_t;

  typedef struct packed {
    logic               valid;
    logic               live;
    logic               dup;
    logic [CNT_W-1:0]   rem;
    logic [VALUE_W-1:0] value;
  } tok_t;

  typedef struct packed {
    logic                   is_list_end;
    logic [VALUE_W-1:0]     value;
    logic                   bad_format;
    logic                   out_of_range;
    logic                   duplicate;
    logic                   list_error;
    logic [ARG_COUNT_W-1:0] arg_count;
  } res_t;

endpackage

// ===== src/dlv_in_if.sv =====
`timescale 1ns / 1ps

interface dlv_in_if;
  logic                      valid;
  logic                      ready;
  logic [dlv_pkg::KIND_W-1:0] kind;
  logic [dlv_pkg::CH_W-1:0]   ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink (input valid, input kind, input ch, output ready);
endinterface

// ===== src/dlv_out_if.sv =====
`timescale 1ns / 1ps

interface dlv_out_if;
  logic                              valid;
  logic                              ready;
  logic                              is_list_end;
  logic signed [dlv_pkg::VALUE_W-1:0] value;
  logic                              bad_format;
  logic                              out_of_range;
  logic                              duplicate;
  logic                              list_error;
  logic [dlv_pkg::ARG_COUNT_W-1:0]   arg_count;

  modport source (
    output valid, output is_list_end, output value, output bad_format,
    output out_of_range, output duplicate, output list_error, output arg_count,
    input ready
  );
  modport sink (
    input valid, input is_list_end, input value, input bad_format,
    input out_of_range, input duplicate, input list_error, input arg_count,
    output ready
  );
endinterface

// ===== src/dlv_parse.sv =====
`timescale 1ns / 1ps

module dlv_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take_i,
  input  logic                     clear_i,
  input  logic [dlv_pkg::CH_W-1:0] ch_i,
  output dlv_pkg::arg_t            arg_o
);
  import dlv_pkg::*;

  logic [1:0]         pos_r, pos_nxt;
  logic               neg_r, neg_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               rexc_r, rexc_nxt;
  logic               ferr_r, ferr_nxt;
  logic               is_digit;
  logic [3:0]         digit;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  limit;

  always_comb begin
    is_digit = ch_i inside {[CH_ZERO:CH_NINE]};
    digit    = 4'(ch_i - CH_ZERO);
    prod     = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + PROD_W'(digit);
    limit    = neg_r ? NEG_LIMIT : POS_LIMIT;
    pos_nxt  = pos_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rexc_nxt = rexc_r;
    ferr_nxt = ferr_r;
    if (clear_i) begin
      pos_nxt  = POS_EMPTY;
      neg_nxt  = 1'b0;
      mag_nxt  = '0;
      rexc_nxt = 1'b0;
      ferr_nxt = 1'b0;
    end else if (take_i) begin
      if (is_digit) begin
        pos_nxt = POS_DIGITS;
        if (!rexc_r) begin
          if (prod > limit) begin
            rexc_nxt = 1'b1;
          end else begin
            mag_nxt = prod[VALUE_W-1:0];
          end
        end
      end else if (pos_r == POS_EMPTY && (ch_i == CH_MINUS || ch_i == CH_PLUS)) begin
        neg_nxt = (ch_i == CH_MINUS);
        pos_nxt = POS_SIGN;
      end else begin
        ferr_nxt = 1'b1;
        if (pos_r == POS_EMPTY) begin
          pos_nxt = POS_DIGITS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_EMPTY;
      neg_r  <= 1'b0;
      mag_r  <= '0;
      rexc_r <= 1'b0;
      ferr_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      neg_r  <= neg_nxt;
      mag_r  <= mag_nxt;
      rexc_r <= rexc_nxt;
      ferr_r <= ferr_nxt;
    end
  end

  assign arg_o.empty = (pos_r == POS_EMPTY);
  assign arg_o.neg   = neg_r;
  assign arg_o.mag   = mag_r;
  assign arg_o.rexc  = rexc_r;
  assign arg_o.ferr  = ferr_r;

endmodule

// ===== src/dlv_cell.sv =====
`timescale 1ns / 1ps

module dlv_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  dlv_pkg::tok_t  tok_i,
  output dlv_pkg::tok_t  tok_o
);
  import dlv_pkg::*;

  logic [VALUE_W-1:0] stored_r;
  tok_t               tok_r, tok_nxt;
  logic               searching;
  logic               at_tail;
  logic               hit;

  always_comb begin
    searching = tok_i.valid && tok_i.live;
    at_tail   = searching && (tok_i.rem == '0);
    hit       = searching && (tok_i.rem != '0) && (stored_r == tok_i.value);
    tok_nxt   = tok_i;
    if (at_tail) begin
      tok_nxt.live = 1'b0;
    end else if (hit) begin
      tok_nxt.live = 1'b0;
      tok_nxt.dup  = 1'b1;
    end else if (searching) begin
      tok_nxt.rem = tok_i.rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (at_tail) begin
      stored_r <= tok_i.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== src/decimal_list_validator.sv =====
`timescale 1ns / 1ps

// Decimal list validator.
// in_req carries one request per cycle at most: a character of the current
// argument, an end of argument, or an end of list. out_res returns one
// verdict per end of argument taken while no error is latched, and one
// summary per end of list. A character gives no result.
// An end of argument that is empty, malformed or out of range is answered
// in the cycle after it is taken. A well-formed one walks a row of MAX_ARGS
// (512) storage cells, one cell per cycle, comparing against every value
// stored so far and landing in the first free cell; its verdict is loaded
// into the output register as it leaves the last cell. An end of list is
// answered in the cycle after it is taken and clears the count, the error
// latch and the current argument. One request is in flight at a time:
// in_req.ready drops during the walk and while a result sits in the output
// register and out_res.ready is low. A stalled result holds its value until
// taken. Reset empties the list, clears the error latch and the output valid
// flag; the storage cells themselves are not cleared.
module decimal_list_validator (
  input  logic      clk,
  input  logic      rst_n,
  dlv_in_if.sink    in_req,
  dlv_out_if.source out_res
);
  import dlv_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r;
  res_t             res_r, res_nxt;
  logic             res_load;
  logic             accept;
  logic             take_char;
  logic             clear_arg;
  arg_t             arg;
  logic [VALUE_W-1:0] arg_value;
  tok_t             launch;
  tok_t             link [0:MAX_ARGS];

  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_res.ready);
  assign accept       = in_req.valid && in_req.ready;
  assign take_char    = accept && (in_req.kind == KIND_CHAR) && !err_r;
  assign clear_arg    = accept && (in_req.kind == KIND_ARG_END ||
                                   in_req.kind == KIND_LIST_END);
  assign arg_value    = arg.neg ? (VALUE_W'(0) - arg.mag) : arg.mag;

  dlv_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take_i  (take_char),
    .clear_i (clear_arg),
    .ch_i    (in_req.ch),
    .arg_o   (arg)
  );

  assign link[0] = launch;

  for (genvar i = 0; i < MAX_ARGS; i++) begin : g_cell
    dlv_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (link[i]),
      .tok_o (link[i+1])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    err_nxt      = err_r;
    res_load     = 1'b0;
    res_nxt      = '0;
    launch       = '0;
    launch.value = arg_value;
    launch.rem   = count_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.kind)
            KIND_ARG_END: begin
              if (!err_r) begin
                if (arg.empty || arg.ferr) begin
                  res_load           = 1'b1;
                  res_nxt.bad_format = 1'b1;
                  err_nxt            = 1'b1;
                end else if (arg.rexc) begin
                  res_load             = 1'b1;
                  res_nxt.out_of_range = 1'b1;
                  err_nxt              = 1'b1;
                end else begin
                  launch.valid = 1'b1;
                  launch.live  = 1'b1;
                  state_nxt    = ST_SEARCH;
                end
                res_nxt.list_error = 1'b1;
                res_nxt.arg_count  = ARG_COUNT_W'(count_r);
              end
            end
            KIND_LIST_END: begin
              res_load            = 1'b1;
              res_nxt.is_list_end = 1'b1;
              res_nxt.list_error  = err_r;
              res_nxt.arg_count   = ARG_COUNT_W'(count_r);
              count_nxt           = '0;
              err_nxt             = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (link[MAX_ARGS].valid) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (link[MAX_ARGS].dup) begin
            res_nxt.duplicate = 1'b1;
            err_nxt           = 1'b1;
          end else if (link[MAX_ARGS].live) begin
            err_nxt = 1'b1;
          end else begin
            res_nxt.value = link[MAX_ARGS].value;
            count_nxt     = count_r + 1'b1;
          end
          res_nxt.list_error = err_nxt;
          res_nxt.arg_count  = ARG_COUNT_W'(count_nxt);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.is_list_end  = res_r.is_list_end;
  assign out_res.value        = $signed(res_r.value);
  assign out_res.bad_format   = res_r.bad_format;
  assign out_res.out_of_range = res_r.out_of_range;
  assign out_res.duplicate    = res_r.duplicate;
  assign out_res.list_error   = res_r.list_error;
  assign out_res.arg_count    = res_r.arg_count;

endmodule

// ===== src/dlv_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dlv_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               is_list_end,
  input logic signed [dlv_pkg::VALUE_W-1:0] value,
  input logic                               bad_format,
  input logic                               out_of_range,
  input logic                               duplicate,
  input logic                               list_error,
  input logic [dlv_pkg::ARG_COUNT_W-1:0]    arg_count
);

  `DLV_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(value) && $stable(arg_count) && $stable(list_error), "stalled result changed")
  `DLV_ASSERT(a_summary_clean, out_valid && is_list_end |-> value == 0 && !bad_format && !out_of_range && !duplicate, "summary carries verdict fields")
  `DLV_ASSERT(a_reject_zero, out_valid && !is_list_end && (bad_format || out_of_range || duplicate) |-> value == 0 && list_error, "rejected argument not flagged")
  `DLV_ASSERT(a_one_reason, out_valid |-> $onehot0({bad_format, out_of_range, duplicate}), "more than one rejection reason")
  `DLV_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind decimal_list_validator dlv_checker u_dlv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .is_list_end  (out_res.is_list_end),
  .value        (out_res.value),
  .bad_format   (out_res.bad_format),
  .out_of_range (out_res.out_of_range),
  .duplicate    (out_res.duplicate),
  .list_error   (out_res.list_error),
  .arg_count    (out_res.arg_count)
);
